FILE: sv/fvls_pkg.sv
// ----------------------------------------------------------------------------
// fvls_pkg
// Shared types, constants and helpers of the FAT volume layout solver.
// ----------------------------------------------------------------------------
package fvls_pkg;

    localparam logic [1:0] ST_OK      = 2'd0;
    localparam logic [1:0] ST_ARGS    = 2'd1;
    localparam logic [1:0] ST_BIG     = 2'd2;
    localparam logic [1:0] ST_INVALID = 2'd3;

    localparam logic [5:0] WIDTH_12 = 6'd12;
    localparam logic [5:0] WIDTH_16 = 6'd16;
    localparam logic [5:0] WIDTH_32 = 6'd32;

    localparam logic [31:0] CLUS_FAT12_LIMIT = 32'd4085;
    localparam logic [31:0] CLUS_FAT16_LIMIT = 32'd65525;

    localparam logic [15:0] ROOT_DEFAULT      = 16'd512;
    localparam logic [15:0] RSV_FAT32_DEFAULT = 16'd32;
    localparam logic [15:0] RSV_FAT32_MIN     = 16'd6;
    localparam logic [15:0] RSV_DEFAULT       = 16'd1;
    localparam logic [7:0]  COPIES_DEFAULT    = 8'd2;
    localparam logic [7:0]  COPIES_MAX        = 8'd8;

    localparam logic [42:0] BYTES_SMALL  = 43'd67108864;
    localparam logic [42:0] BYTES_MEDIUM = 43'd268435456;
    localparam logic [42:0] BYTES_LARGE  = 43'd8589934592;

    // log2 of the cluster byte targets 512, 4096, 8192 and 32768
    localparam logic [3:0] TGT_LOG_SMALL  = 4'd9;
    localparam logic [3:0] TGT_LOG_MEDIUM = 4'd12;
    localparam logic [3:0] TGT_LOG_LARGE  = 4'd13;
    localparam logic [3:0] TGT_LOG_HUGE   = 4'd15;
    localparam logic [3:0] SECTOR_LOG_MIN = 4'd9;

    localparam logic [3:0] LAST_ROUND   = 4'd15;
    localparam logic [1:0] LAST_ATTEMPT = 2'd3;

    localparam int QUEUE_DEPTH_DEFAULT = 2;

    typedef struct packed {
        logic [1:0]  status;
        logic [1:0]  sh;
        logic [31:0] total;
        logic [3:0]  copies;
        logic [7:0]  spc;
        logic [2:0]  spc_log;
        logic [5:0]  want;
        logic [5:0]  rq_w;
        logic [15:0] rq_root;
        logic [15:0] rq_rsv;
    } job_t;

    typedef struct packed {
        logic [1:0]  status;
        logic [5:0]  width_bits;
        logic [11:0] sector_bytes;
        logic [31:0] volume_sectors;
        logic [7:0]  cluster_sectors;
        logic [15:0] reserved_count;
        logic [15:0] root_slot_count;
        logic [12:0] root_dir_size;
        logic [31:0] table_sectors;
        logic [31:0] data_start;
        logic [31:0] cluster_count;
    } res_t;

    function automatic logic [5:0] width_for(input logic [31:0] clusters);
        logic [5:0] w;
        if (clusters < CLUS_FAT12_LIMIT)
            w = WIDTH_12;
        else if (clusters < CLUS_FAT16_LIMIT)
            w = WIDTH_16;
        else
            w = WIDTH_32;
        return w;
    endfunction

    function automatic logic [34:0] table_bytes(input logic [32:0] n, input logic [5:0] bits);
        logic [34:0] t;
        if (bits == WIDTH_12)
        begin
            t = {2'b00, n} + {1'b0, n, 1'b0} + 35'd1;
            t = t >> 1;
        end
        else if (bits == WIDTH_16)
            t = {1'b0, n, 1'b0};
        else
            t = {n, 2'b00};
        return t;
    endfunction

endpackage

FILE: sv/fvls_front.sv
// ----------------------------------------------------------------------------
// fvls_front
// Accepts a format request, applies defaults, validates it and issues a job.
// ----------------------------------------------------------------------------
module fvls_front
    import fvls_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    output logic        in_ready,
    input  logic [15:0] req_sector_bytes,
    input  logic [15:0] device_block_bytes,
    input  logic [47:0] device_capacity_bytes,
    input  logic [31:0] req_volume_sectors,
    input  logic [7:0]  req_table_copies,
    input  logic [7:0]  req_cluster_sectors,
    input  logic [5:0]  req_width,
    input  logic [15:0] req_root_slots,
    input  logic [15:0] req_reserved,
    output logic        job_valid,
    input  logic        job_ready,
    output job_t        job
);

    typedef enum logic [1:0] {F_IDLE, F_DECODE, F_CLASS, F_PUSH} fstate_t;

    fstate_t     state_reg, state_next;
    logic [15:0] bps_rq_reg, bps_rq_next, bps_dev_reg, bps_dev_next;
    logic [47:0] cap_reg, cap_next;
    logic [31:0] vol_reg, vol_next;
    logic [7:0]  cop_reg, cop_next, spc_rq_reg, spc_rq_next;
    logic [5:0]  w_reg, w_next;
    logic [15:0] root_reg, root_next, rsv_reg, rsv_next;
    logic [1:0]  err_reg, err_next, sh_reg, sh_next;
    logic [31:0] total_reg, total_next;
    job_t        job_reg, job_next;

    logic [15:0] bps_sel;
    logic [1:0]  sh_c;
    logic        bps_ok;
    logic [38:0] devsec;
    logic [7:0]  copies;
    logic [42:0] vbytes;
    logic [3:0]  tgt_log, base_log;
    logic [2:0]  pick_log, spc_log;
    logic [7:0]  spc_sel;
    logic        spc_ok;
    logic        w_ok;
    logic [5:0]  want;
    logic [1:0]  st_c;

    assign in_ready  = (state_reg == F_IDLE);
    assign job_valid = (state_reg == F_PUSH);
    assign job       = job_reg;

    always_comb
    begin
        bps_sel = (bps_rq_reg != 16'd0) ? bps_rq_reg : bps_dev_reg;
        bps_ok  = 1'b1;
        case (bps_sel)
            16'd512:  sh_c = 2'd0;
            16'd1024: sh_c = 2'd1;
            16'd2048: sh_c = 2'd2;
            default:
            begin
                sh_c   = 2'd0;
                bps_ok = 1'b0;
            end
        endcase
        case (sh_c)
            2'd1:    devsec = 39'(cap_reg >> 10);
            2'd2:    devsec = 39'(cap_reg >> 11);
            default: devsec = 39'(cap_reg >> 9);
        endcase

        copies   = (cop_reg != 8'd0) ? cop_reg : COPIES_DEFAULT;
        vbytes   = {11'd0, total_reg} << (SECTOR_LOG_MIN + {2'b00, sh_reg});
        if (vbytes <= BYTES_SMALL)
            tgt_log = TGT_LOG_SMALL;
        else if (vbytes <= BYTES_MEDIUM)
            tgt_log = TGT_LOG_MEDIUM;
        else if (vbytes <= BYTES_LARGE)
            tgt_log = TGT_LOG_LARGE;
        else
            tgt_log = TGT_LOG_HUGE;
        base_log = SECTOR_LOG_MIN + {2'b00, sh_reg};
        pick_log = (tgt_log > base_log) ? 3'(tgt_log - base_log) : 3'd0;
        spc_sel  = (spc_rq_reg != 8'd0) ? spc_rq_reg : (8'd1 << pick_log);
        spc_ok   = 1'b1;
        case (spc_sel)
            8'd1:    spc_log = 3'd0;
            8'd2:    spc_log = 3'd1;
            8'd4:    spc_log = 3'd2;
            8'd8:    spc_log = 3'd3;
            8'd16:   spc_log = 3'd4;
            8'd32:   spc_log = 3'd5;
            8'd64:   spc_log = 3'd6;
            8'd128:  spc_log = 3'd7;
            default:
            begin
                spc_log = 3'd0;
                spc_ok  = 1'b0;
            end
        endcase
        w_ok = (w_reg == 6'd0) || (w_reg inside {WIDTH_12, WIDTH_16, WIDTH_32});
        want = (w_reg != 6'd0) ? w_reg : width_for(total_reg >> spc_log);

        if (err_reg != ST_OK)
            st_c = err_reg;
        else if (copies > COPIES_MAX || !spc_ok || !w_ok)
            st_c = ST_ARGS;
        else
            st_c = ST_OK;
    end

    always_comb
    begin
        state_next   = state_reg;
        bps_rq_next  = bps_rq_reg;
        bps_dev_next = bps_dev_reg;
        cap_next     = cap_reg;
        vol_next     = vol_reg;
        cop_next     = cop_reg;
        spc_rq_next  = spc_rq_reg;
        w_next       = w_reg;
        root_next    = root_reg;
        rsv_next     = rsv_reg;
        err_next     = err_reg;
        sh_next      = sh_reg;
        total_next   = total_reg;
        job_next     = job_reg;
        case (state_reg)
            F_IDLE:
            begin
                if (in_valid)
                begin
                    bps_rq_next  = req_sector_bytes;
                    bps_dev_next = device_block_bytes;
                    cap_next     = device_capacity_bytes;
                    vol_next     = req_volume_sectors;
                    cop_next     = req_table_copies;
                    spc_rq_next  = req_cluster_sectors;
                    w_next       = req_width;
                    root_next    = req_root_slots;
                    rsv_next     = req_reserved;
                    state_next   = F_DECODE;
                end
            end
            F_DECODE:
            begin
                sh_next = sh_c;
                if (!bps_ok)
                    err_next = ST_ARGS;
                else if (devsec == 39'd0)
                    err_next = ST_BIG;
                else if (vol_reg != 32'd0 && 39'(vol_reg) > devsec)
                    err_next = ST_ARGS;
                else
                    err_next = ST_OK;
                if (vol_reg != 32'd0)
                    total_next = vol_reg;
                else if (devsec > 39'h00FFFFFFFF)
                    total_next = '1;
                else
                    total_next = devsec[31:0];
                state_next = F_CLASS;
            end
            F_CLASS:
            begin
                job_next.status  = st_c;
                job_next.sh      = sh_reg;
                job_next.total   = total_reg;
                job_next.copies  = copies[3:0];
                job_next.spc     = spc_sel;
                job_next.spc_log = spc_log;
                job_next.want    = want;
                job_next.rq_w    = w_reg;
                job_next.rq_root = root_reg;
                job_next.rq_rsv  = rsv_reg;
                state_next       = F_PUSH;
            end
            F_PUSH:
            begin
                if (job_ready)
                    state_next = F_IDLE;
            end
            default: state_next = F_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg   <= F_IDLE;
            bps_rq_reg  <= '0;
            bps_dev_reg <= '0;
            cap_reg     <= '0;
            vol_reg     <= '0;
            cop_reg     <= '0;
            spc_rq_reg  <= '0;
            w_reg       <= '0;
            root_reg    <= '0;
            rsv_reg     <= '0;
            err_reg     <= ST_OK;
            sh_reg      <= '0;
            total_reg   <= '0;
            job_reg     <= '0;
        end
        else
        begin
            state_reg   <= state_next;
            bps_rq_reg  <= bps_rq_next;
            bps_dev_reg <= bps_dev_next;
            cap_reg     <= cap_next;
            vol_reg     <= vol_next;
            cop_reg     <= cop_next;
            spc_rq_reg  <= spc_rq_next;
            w_reg       <= w_next;
            root_reg    <= root_next;
            rsv_reg     <= rsv_next;
            err_reg     <= err_next;
            sh_reg      <= sh_next;
            total_reg   <= total_next;
            job_reg     <= job_next;
        end
    end

endmodule

FILE: sv/fvls_queue.sv
// ----------------------------------------------------------------------------
// fvls_queue
// Short job queue between the front and the back.
// ----------------------------------------------------------------------------
module fvls_queue
    import fvls_pkg::*;
#(
    parameter int DEPTH = QUEUE_DEPTH_DEFAULT
)
(
    input  logic clk,
    input  logic rst_n,
    input  logic push_valid,
    output logic push_ready,
    input  job_t push_job,
    output logic pop_valid,
    input  logic pop_ready,
    output job_t pop_job
);

    localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW = $clog2(DEPTH + 1);

    job_t          slot_reg [DEPTH];
    logic [PW-1:0] wr_reg, rd_reg;
    logic [CW-1:0] cnt_reg;
    logic          do_push, do_pop;

    assign push_ready = (cnt_reg != CW'(DEPTH));
    assign pop_valid  = (cnt_reg != '0);
    assign pop_job    = slot_reg[rd_reg];
    assign do_push    = push_valid && push_ready;
    assign do_pop     = pop_valid && pop_ready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_reg  <= '0;
            rd_reg  <= '0;
            cnt_reg <= '0;
        end
        else
        begin
            if (do_push)
                wr_reg <= (wr_reg == PW'(DEPTH - 1)) ? '0 : wr_reg + 1'b1;
            if (do_pop)
                rd_reg <= (rd_reg == PW'(DEPTH - 1)) ? '0 : rd_reg + 1'b1;
            if (do_push && !do_pop)
                cnt_reg <= cnt_reg + 1'b1;
            else if (do_pop && !do_push)
                cnt_reg <= cnt_reg - 1'b1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_push)
            slot_reg[wr_reg] <= push_job;
    end

endmodule

FILE: sv/fvls_back.sv
// ----------------------------------------------------------------------------
// fvls_back
// Solves the FAT size fixed point per width attempt and holds the result.
// ----------------------------------------------------------------------------
module fvls_back
    import fvls_pkg::*;
(
    input  logic clk,
    input  logic rst_n,
    input  logic job_valid,
    output logic job_ready,
    input  job_t job,
    output logic out_valid,
    input  logic out_ready,
    output res_t result
);

    typedef enum logic [3:0] {
        B_IDLE, B_ATTEMPT, B_OVER, B_CLUS, B_TB, B_TEST, B_MCLUS, B_MTB, B_MCHK, B_DONE
    } bstate_t;

    bstate_t     state_reg, state_next;
    job_t        job_reg, job_next;
    logic [5:0]  want_reg, want_next;
    logic [1:0]  att_reg, att_next;
    logic [3:0]  round_reg, round_next;
    logic [31:0] spf_reg, spf_next;
    logic [15:0] roots_reg, roots_next, rsv_reg, rsv_next;
    logic [12:0] rds_reg, rds_next;
    logic [35:0] over_reg, over_next;
    logic [31:0] clus_reg, clus_next, mclus_reg, mclus_next;
    logic [34:0] tb_reg, tb_next;
    logic [1:0]  st_reg, st_next;
    logic        ov_reg, ov_next;
    res_t        res_reg, res_next;

    logic [3:0]  sec_log;
    logic [11:0] bps;
    logic [15:0] roots_c, rsv_c, rmask;
    logic [16:0] rsum;
    logic [26:0] need;
    logic [43:0] fat_bytes;
    logic [5:0]  sel;

    assign job_ready = (state_reg == B_IDLE);
    assign out_valid = ov_reg;
    assign result    = res_reg;

    always_comb
    begin
        sec_log   = SECTOR_LOG_MIN + {2'b00, job_reg.sh};
        bps       = 12'd512 << job_reg.sh;
        roots_c   = (job_reg.rq_root != 16'd0) ? job_reg.rq_root : ROOT_DEFAULT;
        rmask     = (16'd16 << job_reg.sh) - 16'd1;
        rsum      = 17'(roots_c) + 17'(rmask);
        need      = 27'((36'(tb_reg) + 36'(bps) - 36'd1) >> sec_log);
        fat_bytes = 44'(spf_reg) << sec_log;
        sel       = width_for(clus_reg);
        if (want_reg == WIDTH_32)
            rsv_c = (job_reg.rq_rsv != 16'd0) ? job_reg.rq_rsv : RSV_FAT32_DEFAULT;
        else
            rsv_c = (job_reg.rq_rsv != 16'd0) ? job_reg.rq_rsv : RSV_DEFAULT;
    end

    always_comb
    begin
        state_next = state_reg;
        job_next   = job_reg;
        want_next  = want_reg;
        att_next   = att_reg;
        round_next = round_reg;
        spf_next   = spf_reg;
        roots_next = roots_reg;
        rsv_next   = rsv_reg;
        rds_next   = rds_reg;
        over_next  = over_reg;
        clus_next  = clus_reg;
        mclus_next = mclus_reg;
        tb_next    = tb_reg;
        st_next    = st_reg;
        ov_next    = ov_reg;
        res_next   = res_reg;
        if (ov_reg && out_ready)
            ov_next = 1'b0;
        case (state_reg)
            B_IDLE:
            begin
                if (job_valid)
                begin
                    job_next  = job;
                    want_next = job.want;
                    att_next  = '0;
                    st_next   = job.status;
                    state_next = (job.status != ST_OK) ? B_DONE : B_ATTEMPT;
                end
            end
            B_ATTEMPT:
            begin
                rsv_next   = rsv_c;
                spf_next   = 32'd1;
                round_next = '0;
                if (want_reg == WIDTH_32)
                begin
                    roots_next = '0;
                    rds_next   = '0;
                    if (job_reg.rq_root != 16'd0 || rsv_c <= RSV_FAT32_MIN)
                    begin
                        st_next    = ST_ARGS;
                        state_next = B_DONE;
                    end
                    else
                        state_next = B_OVER;
                end
                else
                begin
                    roots_next = roots_c;
                    rds_next   = 13'(rsum >> (job_reg.sh + 2'd0 + 4'd4));
                    if ((roots_c & rmask) != 16'd0)
                    begin
                        st_next    = ST_ARGS;
                        state_next = B_DONE;
                    end
                    else
                        state_next = B_OVER;
                end
            end
            B_OVER:
            begin
                over_next  = 36'(rsv_reg) + 36'(job_reg.copies) * 36'(spf_reg) + 36'(rds_reg);
                state_next = B_CLUS;
            end
            B_CLUS:
            begin
                if (over_reg >= 36'(job_reg.total))
                begin
                    st_next    = ST_BIG;
                    state_next = B_DONE;
                end
                else
                begin
                    clus_next  = (job_reg.total - over_reg[31:0]) >> job_reg.spc_log;
                    state_next = B_TB;
                end
            end
            B_TB:
            begin
                tb_next    = table_bytes(33'(clus_reg) + 33'd2, want_reg);
                state_next = B_TEST;
            end
            B_TEST:
            begin
                if (32'(need) <= spf_reg)
                begin
                    if (sel == want_reg)
                        state_next = B_MCLUS;
                    else if (job_reg.rq_w != 6'd0)
                    begin
                        st_next    = ST_ARGS;
                        state_next = B_DONE;
                    end
                    else if (att_reg == LAST_ATTEMPT)
                    begin
                        st_next    = ST_INVALID;
                        state_next = B_DONE;
                    end
                    else
                    begin
                        want_next  = sel;
                        att_next   = att_reg + 2'd1;
                        state_next = B_ATTEMPT;
                    end
                end
                else if (round_reg == LAST_ROUND)
                begin
                    st_next    = ST_INVALID;
                    state_next = B_DONE;
                end
                else
                begin
                    spf_next   = 32'(need);
                    round_next = round_reg + 4'd1;
                    state_next = B_OVER;
                end
            end
            B_MCLUS:
            begin
                mclus_next = (job_reg.total - over_reg[31:0]) >> job_reg.spc_log;
                state_next = B_MTB;
            end
            B_MTB:
            begin
                tb_next    = table_bytes(33'(mclus_reg) + 33'd2, want_reg);
                state_next = B_MCHK;
            end
            B_MCHK:
            begin
                if (mclus_reg != clus_reg)
                    st_next = ST_INVALID;
                else if (width_for(mclus_reg) != want_reg)
                    st_next = ST_ARGS;
                else if (fat_bytes < 44'(tb_reg))
                    st_next = ST_INVALID;
                else
                    st_next = ST_OK;
                state_next = B_DONE;
            end
            B_DONE:
            begin
                if (!ov_reg || out_ready)
                begin
                    res_next = '0;
                    res_next.status = st_reg;
                    if (st_reg == ST_OK)
                    begin
                        res_next.width_bits      = want_reg;
                        res_next.sector_bytes    = bps;
                        res_next.volume_sectors  = job_reg.total;
                        res_next.cluster_sectors = job_reg.spc;
                        res_next.reserved_count  = rsv_reg;
                        res_next.root_slot_count = roots_reg;
                        res_next.root_dir_size   = rds_reg;
                        res_next.table_sectors   = spf_reg;
                        res_next.data_start      = over_reg[31:0];
                        res_next.cluster_count   = clus_reg;
                    end
                    ov_next    = 1'b1;
                    state_next = B_IDLE;
                end
            end
            default: state_next = B_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= B_IDLE;
            job_reg   <= '0;
            want_reg  <= '0;
            att_reg   <= '0;
            round_reg <= '0;
            spf_reg   <= '0;
            roots_reg <= '0;
            rsv_reg   <= '0;
            rds_reg   <= '0;
            over_reg  <= '0;
            clus_reg  <= '0;
            mclus_reg <= '0;
            tb_reg    <= '0;
            st_reg    <= ST_OK;
            ov_reg    <= 1'b0;
            res_reg   <= '0;
        end
        else
        begin
            state_reg <= state_next;
            job_reg   <= job_next;
            want_reg  <= want_next;
            att_reg   <= att_next;
            round_reg <= round_next;
            spf_reg   <= spf_next;
            roots_reg <= roots_next;
            rsv_reg   <= rsv_next;
            rds_reg   <= rds_next;
            over_reg  <= over_next;
            clus_reg  <= clus_next;
            mclus_reg <= mclus_next;
            tb_reg    <= tb_next;
            st_reg    <= st_next;
            ov_reg    <= ov_next;
            res_reg   <= res_next;
        end
    end

endmodule

FILE: sv/fat_volume_layout_solver.sv
// A request rejected up front goes straight to the result; otherwise the
// solver runs fixed-point rounds within each width attempt.
// Throughput: one request at a time in the solver; the front validates the
// next request and queues it meanwhile. The solver's round loop sets the rate.
// Reset: rst_n clears the queue, both sequencers and the result valid flag.
// ----------------------------------------------------------------------------
// fat_volume_layout_solver
// Top level: request front, job queue and layout solver back.
// ----------------------------------------------------------------------------
module fat_volume_layout_solver
    import fvls_pkg::*;
#(
    parameter int QUEUE_DEPTH = QUEUE_DEPTH_DEFAULT
)
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    output logic        in_ready,
    input  logic [15:0] req_sector_bytes,
    input  logic [15:0] device_block_bytes,
    input  logic [47:0] device_capacity_bytes,
    input  logic [31:0] req_volume_sectors,
    input  logic [7:0]  req_table_copies,
    input  logic [7:0]  req_cluster_sectors,
    input  logic [5:0]  req_width,
    input  logic [15:0] req_root_slots,
    input  logic [15:0] req_reserved,
    output logic        out_valid,
    input  logic        out_ready,
    output logic [1:0]  status,
    output logic [5:0]  width_bits,
    output logic [11:0] sector_bytes,
    output logic [31:0] volume_sectors,
    output logic [7:0]  cluster_sectors,
    output logic [15:0] reserved_count,
    output logic [15:0] root_slot_count,
    output logic [12:0] root_dir_size,
    output logic [31:0] table_sectors,
    output logic [31:0] data_start,
    output logic [31:0] cluster_count
);

    logic fq_valid, fq_ready, qb_valid, qb_ready;
    job_t fq_job, qb_job;
    res_t res;

    fvls_front u_front (
        .clk                   (clk),
        .rst_n                 (rst_n),
        .in_valid              (in_valid),
        .in_ready              (in_ready),
        .req_sector_bytes      (req_sector_bytes),
        .device_block_bytes    (device_block_bytes),
        .device_capacity_bytes (device_capacity_bytes),
        .req_volume_sectors    (req_volume_sectors),
        .req_table_copies      (req_table_copies),
        .req_cluster_sectors   (req_cluster_sectors),
        .req_width             (req_width),
        .req_root_slots        (req_root_slots),
        .req_reserved          (req_reserved),
        .job_valid             (fq_valid),
        .job_ready             (fq_ready),
        .job                   (fq_job)
    );

    fvls_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .clk        (clk),
        .rst_n      (rst_n),
        .push_valid (fq_valid),
        .push_ready (fq_ready),
        .push_job   (fq_job),
        .pop_valid  (qb_valid),
        .pop_ready  (qb_ready),
        .pop_job    (qb_job)
    );

    fvls_back u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .job_valid (qb_valid),
        .job_ready (qb_ready),
        .job       (qb_job),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .result    (res)
    );

    assign status          = res.status;
    assign width_bits      = res.width_bits;
    assign sector_bytes    = res.sector_bytes;
    assign volume_sectors  = res.volume_sectors;
    assign cluster_sectors = res.cluster_sectors;
    assign reserved_count  = res.reserved_count;
    assign root_slot_count = res.root_slot_count;
    assign root_dir_size   = res.root_dir_size;
    assign table_sectors   = res.table_sectors;
    assign data_start      = res.data_start;
    assign cluster_count   = res.cluster_count;

    a_err_clear: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && status != ST_OK |-> width_bits == 6'd0 && cluster_count == 32'd0
        && table_sectors == 32'd0)
        else $error("error result carries layout");

    a_ok_width: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && status == ST_OK |->
        (width_bits == WIDTH_12 || width_bits == WIDTH_16 || width_bits == WIDTH_32))
        else $error("bad width in result");

    a_ok_spc: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && status == ST_OK |-> $onehot(cluster_sectors))
        else $error("cluster size not a power of two");

    a_ok_data: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && status == ST_OK |-> data_start < volume_sectors)
        else $error("data area beyond volume");

endmodule

FILE: tb/fat_volume_layout_solver_test.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// FAT volume layout solver testbench
// Drives format requests through the valid/ready front and compares every
// layout result against a behavioural solver, with random stalls on both sides.
// ----------------------------------------------------------------------------

class layout_scoreboard;
    fvls_pkg::res_t pending[$];
    int unsigned    errors;

    function new();
        errors = 0;
    endfunction

    function automatic logic [34:0] fat_bytes(logic [32:0] n, logic [5:0] bits);
        logic [34:0] t;
        if (bits == fvls_pkg::WIDTH_12)
            t = ({2'b00, n} * 35'd3 + 35'd1) >> 1;
        else if (bits == fvls_pkg::WIDTH_16)
            t = {2'b00, n} * 35'd2;
        else
            t = {2'b00, n} * 35'd4;
        return t;
    endfunction

    function automatic logic [5:0] pick_width(logic [31:0] clus);
        logic [5:0] w;
        if (clus < 32'd4085)
            w = fvls_pkg::WIDTH_12;
        else if (clus < 32'd65525)
            w = fvls_pkg::WIDTH_16;
        else
            w = fvls_pkg::WIDTH_32;
        return w;
    endfunction

    function automatic fvls_pkg::res_t predict_layout(
        logic [15:0] rq_bps, logic [15:0] dev_bs, logic [47:0] cap,
        logic [31:0] rq_vol, logic [7:0] rq_cop, logic [7:0] rq_spc,
        logic [5:0] rq_w, logic [15:0] rq_root, logic [15:0] rq_rsv);
        fvls_pkg::res_t r;
        logic [63:0] bps, devsec, total, copies, spc, rsv, roots, rds, spf;
        logic [63:0] over, clus, need, bytes, tgt, dstart, nclus;
        logic [5:0]  want, sel;
        logic [1:0]  st;
        bit          done, settled;
        r = '0;
        st = fvls_pkg::ST_OK;
        done = 0;
        bps = (rq_bps != 0) ? rq_bps : dev_bs;
        if (bps != 512 && bps != 1024 && bps != 2048)
        begin
            r.status = fvls_pkg::ST_ARGS;
            return r;
        end
        devsec = cap / bps;
        if (devsec == 0)
        begin
            r.status = fvls_pkg::ST_BIG;
            return r;
        end
        if (rq_vol != 0)
        begin
            if (rq_vol > devsec)
            begin
                r.status = fvls_pkg::ST_ARGS;
                return r;
            end
            total = rq_vol;
        end
        else
            total = (devsec > 64'hFFFF_FFFF) ? 64'hFFFF_FFFF : devsec;
        copies = (rq_cop != 0) ? rq_cop : 2;
        if (copies > 8)
        begin
            r.status = fvls_pkg::ST_ARGS;
            return r;
        end
        if (rq_spc != 0)
            spc = rq_spc;
        else
        begin
            bytes = total * bps;
            if (bytes <= 64'd67108864) tgt = 512;
            else if (bytes <= 64'd268435456) tgt = 4096;
            else if (bytes <= 64'd8589934592) tgt = 8192;
            else tgt = 32768;
            spc = tgt / bps;
            if (spc < 1) spc = 1;
            if (spc > 128) spc = 128;
        end
        if (spc < 1 || spc > 128 || (spc & (spc - 1)) != 0)
        begin
            r.status = fvls_pkg::ST_ARGS;
            return r;
        end
        if (rq_w != 0 && rq_w != fvls_pkg::WIDTH_12 && rq_w != fvls_pkg::WIDTH_16
            && rq_w != fvls_pkg::WIDTH_32)
        begin
            r.status = fvls_pkg::ST_ARGS;
            return r;
        end
        want = (rq_w != 0) ? rq_w : pick_width(total / spc);
        settled = 0;
        for (int a = 0; a < 4 && !settled; a++)
        begin
            if (want == fvls_pkg::WIDTH_32)
            begin
                if (rq_root != 0)
                begin
                    r.status = fvls_pkg::ST_ARGS;
                    return r;
                end
                roots = 0;
                rsv = (rq_rsv != 0) ? rq_rsv : 32;
                if (rsv <= 6)
                begin
                    r.status = fvls_pkg::ST_ARGS;
                    return r;
                end
                rds = 0;
            end
            else
            begin
                roots = (rq_root != 0) ? rq_root : 512;
                if (roots % (bps / 32) != 0)
                begin
                    r.status = fvls_pkg::ST_ARGS;
                    return r;
                end
                rsv = (rq_rsv != 0) ? rq_rsv : 1;
                rds = (roots * 32 + bps - 1) / bps;
            end
            spf = 1;
            done = 0;
            for (int k = 0; k < 16 && !done; k++)
            begin
                over = rsv + copies * spf + rds;
                if (over >= total)
                begin
                    r.status = fvls_pkg::ST_BIG;
                    return r;
                end
                clus = (total - over) / spc;
                need = (fat_bytes(clus + 2, want) + bps - 1) / bps;
                if (need[31:0] <= spf)
                begin
                    dstart = over;
                    nclus = clus;
                    done = 1;
                end
                else
                    spf = need[31:0];
            end
            if (!done)
            begin
                r.status = fvls_pkg::ST_INVALID;
                return r;
            end
            sel = pick_width(nclus);
            if (sel == want)
                settled = 1;
            else
            begin
                if (rq_w != 0)
                begin
                    r.status = fvls_pkg::ST_ARGS;
                    return r;
                end
                want = sel;
            end
        end
        if (!settled)
        begin
            r.status = fvls_pkg::ST_INVALID;
            return r;
        end
        clus = (total - dstart) / spc;
        if (clus != nclus)
            st = fvls_pkg::ST_INVALID;
        else if (pick_width(clus) != want)
            st = fvls_pkg::ST_ARGS;
        else if (spf * bps < fat_bytes(clus + 2, want))
            st = fvls_pkg::ST_INVALID;
        if (st != fvls_pkg::ST_OK)
        begin
            r.status = st;
            return r;
        end
        r.width_bits = want;
        r.sector_bytes = bps[11:0];
        r.volume_sectors = total[31:0];
        r.cluster_sectors = spc[7:0];
        r.reserved_count = rsv[15:0];
        r.root_slot_count = roots[15:0];
        r.root_dir_size = rds[12:0];
        r.table_sectors = spf[31:0];
        r.data_start = dstart[31:0];
        r.cluster_count = nclus[31:0];
        return r;
    endfunction

    function void note_request(
        logic [15:0] a, logic [15:0] b, logic [47:0] c, logic [31:0] d,
        logic [7:0] e, logic [7:0] f, logic [5:0] g, logic [15:0] h, logic [15:0] i);
        pending.push_back(predict_layout(a, b, c, d, e, f, g, h, i));
    endfunction

    function void check_result(fvls_pkg::res_t got);
        fvls_pkg::res_t exp;
        if (pending.size() == 0)
        begin
            $display("%0t: unexpected result %h", $time, got);
            errors++;
            return;
        end
        exp = pending.pop_front();
        if (got.status != exp.status)
            $display("%0t: status exp %0d got %0d", $time, exp.status, got.status);
        if (got.width_bits != exp.width_bits)
            $display("%0t: width_bits exp %0d got %0d", $time, exp.width_bits, got.width_bits);
        if (got.sector_bytes != exp.sector_bytes)
            $display("%0t: sector_bytes exp %0d got %0d", $time,
                     exp.sector_bytes, got.sector_bytes);
        if (got.volume_sectors != exp.volume_sectors)
            $display("%0t: volume_sectors exp %0d got %0d", $time,
                     exp.volume_sectors, got.volume_sectors);
        if (got.cluster_sectors != exp.cluster_sectors)
            $display("%0t: cluster_sectors exp %0d got %0d", $time,
                     exp.cluster_sectors, got.cluster_sectors);
        if (got.reserved_count != exp.reserved_count)
            $display("%0t: reserved_count exp %0d got %0d", $time,
                     exp.reserved_count, got.reserved_count);
        if (got.root_slot_count != exp.root_slot_count)
            $display("%0t: root_slot_count exp %0d got %0d", $time,
                     exp.root_slot_count, got.root_slot_count);
        if (got.root_dir_size != exp.root_dir_size)
            $display("%0t: root_dir_size exp %0d got %0d", $time,
                     exp.root_dir_size, got.root_dir_size);
        if (got.table_sectors != exp.table_sectors)
            $display("%0t: table_sectors exp %0d got %0d", $time,
                     exp.table_sectors, got.table_sectors);
        if (got.data_start != exp.data_start)
            $display("%0t: data_start exp %0d got %0d", $time,
                     exp.data_start, got.data_start);
        if (got.cluster_count != exp.cluster_count)
            $display("%0t: cluster_count exp %0d got %0d", $time,
                     exp.cluster_count, got.cluster_count);
        if (got != exp)
            errors++;
    endfunction
endclass

module fat_volume_layout_solver_test;
    import fvls_pkg::*;

    logic        clk;
    logic        rst_n;
    logic        in_valid;
    logic        in_ready;
    logic [15:0] req_sector_bytes;
    logic [15:0] device_block_bytes;
    logic [47:0] device_capacity_bytes;
    logic [31:0] req_volume_sectors;
    logic [7:0]  req_table_copies;
    logic [7:0]  req_cluster_sectors;
    logic [5:0]  req_width;
    logic [15:0] req_root_slots;
    logic [15:0] req_reserved;
    logic        out_valid;
    logic        out_ready;
    logic [1:0]  status;
    logic [5:0]  width_bits;
    logic [11:0] sector_bytes;
    logic [31:0] volume_sectors;
    logic [7:0]  cluster_sectors;
    logic [15:0] reserved_count;
    logic [15:0] root_slot_count;
    logic [12:0] root_dir_size;
    logic [31:0] table_sectors;
    logic [31:0] data_start;
    logic [31:0] cluster_count;

    int unsigned send_idle_pct;
    int unsigned recv_idle_pct;
    layout_scoreboard layouts;

    fat_volume_layout_solver DUT (.*);

    initial
    begin
        clk = 1'b0;
    end

    always
    begin
        #1 clk = 1'b1;
        #1 clk = 1'b0;
    end

    initial
    begin
        #50_000_000;
        $display("Test completed with failures");
        $finish;
    end

    always @(posedge clk)
    begin
        if (rst_n)
        begin
            out_ready <= ($urandom_range(99) >= recv_idle_pct);
            if (out_valid && out_ready)
                layouts.check_result('{status, width_bits, sector_bytes, volume_sectors,
                    cluster_sectors, reserved_count, root_slot_count, root_dir_size,
                    table_sectors, data_start, cluster_count});
        end
        else
            out_ready <= 1'b0;
    end

    task automatic send_request(logic [15:0] a, logic [15:0] b, logic [47:0] c,
                                logic [31:0] d, logic [7:0] e, logic [7:0] f,
                                logic [5:0] g, logic [15:0] h, logic [15:0] i);
        while ($urandom_range(99) < send_idle_pct)
        begin
            in_valid <= 1'b0;
            @(posedge clk);
        end
        in_valid <= 1'b1;
        req_sector_bytes <= a;
        device_block_bytes <= b;
        device_capacity_bytes <= c;
        req_volume_sectors <= d;
        req_table_copies <= e;
        req_cluster_sectors <= f;
        req_width <= g;
        req_root_slots <= h;
        req_reserved <= i;
        @(posedge clk);
        while (!in_ready)
            @(posedge clk);
        layouts.note_request(a, b, c, d, e, f, g, h, i);
    endtask

    task automatic send_random();
        logic [15:0] bps, dev, roots, rsv;
        logic [47:0] cap;
        logic [31:0] vol;
        logic [7:0]  cop, spc;
        logic [5:0]  w;
        int unsigned sel;
        int unsigned bl;
        sel = $urandom_range(9);
        bl = 512 << $urandom_range(2);
        bps = ($urandom_range(3) == 0) ? 16'(bl) : 16'd0;
        dev = 16'(bl);
        case ($urandom_range(3))
            0: cap = 48'($urandom_range(4000, 1)) * 48'(bl);
            1: cap = 48'($urandom) * 48'($urandom_range(64));
            2: cap = 48'({$urandom, $urandom}) & ((48'd1 << $urandom_range(47, 20)) - 48'd1);
            default: cap = {16'($urandom), $urandom};
        endcase
        vol = ($urandom_range(2) == 0) ? 32'($urandom_range(20000, 1)) : 32'd0;
        cop = ($urandom_range(2) == 0) ? 8'($urandom_range(8)) : 8'd0;
        spc = ($urandom_range(1) == 0) ? 8'(1 << $urandom_range(7)) : 8'd0;
        w = 6'd0;
        case ($urandom_range(5))
            0: w = WIDTH_12;
            1: w = WIDTH_16;
            2: w = WIDTH_32;
            default: w = 6'd0;
        endcase
        roots = ($urandom_range(2) == 0) ? 16'(($urandom_range(64)) * 64) : 16'd0;
        rsv = ($urandom_range(2) == 0) ? 16'($urandom_range(64)) : 16'd0;
        if (sel == 0)
        begin
            bps = 16'($urandom);
            dev = 16'($urandom);
            cop = 8'($urandom);
            spc = 8'($urandom);
            w = 6'($urandom);
            roots = 16'($urandom);
            rsv = 16'($urandom);
            vol = $urandom;
        end
        send_request(bps, dev, cap, vol, cop, spc, w, roots, rsv);
    endtask

    task automatic run_phase(int unsigned snd, int unsigned rcv, int unsigned n);
        send_idle_pct = snd;
        recv_idle_pct = rcv;
        repeat (n)
            send_random();
        in_valid <= 1'b0;
    endtask

    initial
    begin
        layouts = new();
        rst_n = 1'b0;
        in_valid = 1'b0;
        req_sector_bytes = '0;
        device_block_bytes = '0;
        device_capacity_bytes = '0;
        req_volume_sectors = '0;
        req_table_copies = '0;
        req_cluster_sectors = '0;
        req_width = '0;
        req_root_slots = '0;
        req_reserved = '0;
        send_idle_pct = 0;
        recv_idle_pct = 0;
        repeat (9) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        send_request(16'd0, 16'd512, 48'd1474560, 32'd0, 8'd0, 8'd0, 6'd0, 16'd0, 16'd0);
        send_request(16'd513, 16'd512, 48'd1474560, 32'd0, 8'd0, 8'd0, 6'd0, 16'd0, 16'd0);
        send_request(16'hFFFF, 16'hFFFF, 48'hFFFF_FFFF_FFFF, 32'hFFFF_FFFF, 8'hFF, 8'hFF,
                     6'h3F, 16'hFFFF, 16'hFFFF);
        send_request(16'd2048, 16'd0, 48'd2047, 32'd0, 8'd0, 8'd0, 6'd0, 16'd0, 16'd0);
        send_request(16'd512, 16'd0, 48'd1024, 32'd3, 8'd0, 8'd0, 6'd0, 16'd0, 16'd0);
        send_request(16'd512, 16'd0, 48'd1474560, 32'd0, 8'd9, 8'd0, 6'd0, 16'd0, 16'd0);
        send_request(16'd512, 16'd0, 48'd1474560, 32'd0, 8'd1, 8'd3, 6'd0, 16'd0, 16'd0);
        send_request(16'd512, 16'd0, 48'd1474560, 32'd0, 8'd8, 8'd128, 6'd0, 16'd0, 16'd0);
        send_request(16'd512, 16'd0, 48'd1474560, 32'd0, 8'd0, 8'd0, 6'd20, 16'd0, 16'd0);
        send_request(16'd512, 16'd0, 48'd1474560, 32'd0, 8'd0, 8'd1, 6'd32, 16'd16, 16'd0);
        send_request(16'd512, 16'd0, 48'd1474560, 32'd0, 8'd0, 8'd1, 6'd32, 16'd0, 16'd5);
        send_request(16'd512, 16'd0, 48'd1474560, 32'd0, 8'd0, 8'd1, 6'd32, 16'd0, 16'd7);
        send_request(16'd2048, 16'd0, 48'd1474560, 32'd0, 8'd0, 8'd0, 6'd12, 16'd10, 16'd0);
        send_request(16'd512, 16'd0, 48'd1474560, 32'd10, 8'd0, 8'd0, 6'd0, 16'd0, 16'd0);
        send_request(16'd512, 16'd0, 48'd1474560, 32'd0, 8'd0, 8'd1, 6'd16, 16'd0, 16'd0);
        send_request(16'd1024, 16'd0, 48'hFFFF_FFFF_FFFF, 32'd0, 8'd0, 8'd0, 6'd0, 16'd0,
                     16'd0);
        send_request(16'd0, 16'd512, 48'd536870912, 32'd0, 8'd0, 8'd0, 6'd0, 16'd0, 16'd0);
        send_request(16'd0, 16'd2048, 48'd34359738368, 32'd0, 8'd0, 8'd0, 6'd0, 16'd0,
                     16'd0);
        send_request(16'd512, 16'd0, 48'd2097152, 32'd4100, 8'd1, 8'd1, 6'd0, 16'd16, 16'd1);
        send_request(16'd512, 16'd0, 48'd67108864, 32'd0, 8'd2, 8'd1, 6'd0, 16'd0, 16'd0);
        in_valid <= 1'b0;

        run_phase(20, 52, 330);
        run_phase(52, 20, 330);
        run_phase(0, 0, 340);

        while (layouts.pending.size() != 0)
            @(posedge clk);
        repeat (300) @(posedge clk);
        if (layouts.errors == 0)
            $display("Test completed successfully");
        else
            $display("Test completed with failures");
        $finish;
    end
endmodule

FILE: files.f
sv/fvls_pkg.sv
sv/fvls_front.sv
sv/fvls_queue.sv
sv/fvls_back.sv
sv/fat_volume_layout_solver.sv
tb/fat_volume_layout_solver_test.sv
